>>> hdl/pae_page_table_walker_defines.svh
// ----------------------------------------------------------------------------
// PAE page table walker assertion macros
// Shared concurrent assertion forms for the walker RTL.
// ----------------------------------------------------------------------------
`ifndef PAE_PAGE_TABLE_WALKER_DEFINES_SVH
`define PAE_PAGE_TABLE_WALKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PTW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// PAE page table walker package
// Item types, configuration type and codes shared by the walker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptw_pkg;

    localparam int VA_W    = 32;
    localparam int ENTRY_W = 64;
    localparam int PA_W    = 52;
    localparam int BASE_W  = 27;
    localparam int MPA_W   = 6;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    // op codes
    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_RESPONSE  = 1'b1;

    // result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // walk status
    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_PAGE_FAULT = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_READ_FAULT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PDPT_BASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PHYS_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_ENABLE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NX_ENABLE     = 2'd3;

    localparam logic [MPA_W-1:0] MAX_PHYS_BITS_RST = 6'd36;

    typedef enum logic [1:0] {
        LVL_IDLE  = 2'd0,
        LVL_PDPTE = 2'd1,
        LVL_PDE   = 2'd2,
        LVL_PTE   = 2'd3
    } t_level;

    typedef struct packed {
        logic               op;
        logic [VA_W-1:0]    lin_addr;
        logic [ENTRY_W-1:0] read_data;
        logic               read_ok;
    } t_req;

    typedef struct packed {
        logic              kind;
        logic [PA_W-1:0]   read_addr;
        logic [PA_W-1:0]   xlat_addr;
        logic [STAT_W-1:0] status;
    } t_rsp;

    typedef struct packed {
        logic [BASE_W-1:0] pdpt_base;
        logic [MPA_W-1:0]  max_phys_bits;
        logic              pat_enable;
        logic              nx_enable;
    } t_cfg;

    // outcome of one item: result, if any, and the walk state update
    typedef struct packed {
        logic   emit;
        logic   latch;
        t_level next_level;
        t_rsp   rsp;
    } t_step;

endpackage

>>> hdl/ptw_chan_if.sv
// ----------------------------------------------------------------------------
// PAE page table walker channels
// Valid/ready interfaces for the request and result streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptw_req_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] lin_addr;
    logic [63:0] read_data;
    logic        read_ok;

    modport source (output valid, op, lin_addr, read_data, read_ok, input ready);
    modport sink   (input valid, op, lin_addr, read_data, read_ok, output ready);
endinterface

interface ptw_rsp_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [51:0] read_addr;
    logic [51:0] xlat_addr;
    logic [1:0]  status;

    modport source (output valid, kind, read_addr, xlat_addr, status, input ready);
    modport sink   (input valid, kind, read_addr, xlat_addr, status, output ready);
endinterface

>>> hdl/ptw_cfg_regs.sv
// ----------------------------------------------------------------------------
// PAE page table walker configuration registers
// Write-only register bank: PDPT base, MAXPHYADDR, PAT and NXE controls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptw_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ptw_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output ptw_pkg::t_cfg                     o_cfg
);

    ptw_pkg::t_cfg r_cfg;
    ptw_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptw_pkg::CFG_PDPT_BASE:     n_cfg.pdpt_base = i_cfg_wdata;
                ptw_pkg::CFG_MAX_PHYS_BITS: n_cfg.max_phys_bits =
                                                i_cfg_wdata[ptw_pkg::MPA_W-1:0];
                ptw_pkg::CFG_PAT_ENABLE:    n_cfg.pat_enable = i_cfg_wdata[0];
                ptw_pkg::CFG_NX_ENABLE:     n_cfg.nx_enable = i_cfg_wdata[0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pdpt_base     <= '0;
            r_cfg.max_phys_bits <= ptw_pkg::MAX_PHYS_BITS_RST;
            r_cfg.pat_enable    <= 1'b1;
            r_cfg.nx_enable     <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/ptw_entry_check.sv
// ----------------------------------------------------------------------------
// PAE page table walker entry check
// Decodes one item against the walk level: next read address, final
// translation, or fault, with the reserved-bit checks for PDE and PTE.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptw_entry_check (
    input  ptw_pkg::t_level              i_level,
    input  logic [ptw_pkg::VA_W-1:0]     i_linear,
    input  ptw_pkg::t_req                i_item,
    input  ptw_pkg::t_cfg                i_cfg,
    output ptw_pkg::t_step               o_step
);

    logic [ptw_pkg::ENTRY_W-1:0] w_hi_rsv;
    logic [ptw_pkg::ENTRY_W-1:0] w_pde_rsv;
    logic [ptw_pkg::ENTRY_W-1:0] w_pte_rsv;
    logic [ptw_pkg::ENTRY_W-1:0] w_e;
    logic                        w_large;

    assign w_e     = i_item.read_data;
    assign w_large = w_e[7];

    // bits 62 down to MAXPHYADDR; out-of-range values saturate at 32 and 52
    always_comb begin
        w_hi_rsv        = '0;
        w_hi_rsv[62:52] = '1;
        for (int b = 32; b < 52; b++) begin
            w_hi_rsv[b] = (6'(b) >= i_cfg.max_phys_bits);
        end
    end

    always_comb begin
        w_pde_rsv     = w_hi_rsv;
        w_pde_rsv[63] = !i_cfg.nx_enable;
        if (w_large) begin
            w_pde_rsv[20:13] = '1;
            w_pde_rsv[12]    = !i_cfg.pat_enable;
        end
    end

    always_comb begin
        w_pte_rsv     = w_hi_rsv;
        w_pte_rsv[63] = !i_cfg.nx_enable;
        w_pte_rsv[7]  = !i_cfg.pat_enable;
    end

    always_comb begin
        o_step            = '0;
        o_step.next_level = i_level;
        if (i_item.op == ptw_pkg::OP_TRANSLATE) begin
            if (i_level == ptw_pkg::LVL_IDLE) begin
                o_step.emit           = 1'b1;
                o_step.latch          = 1'b1;
                o_step.next_level     = ptw_pkg::LVL_PDPTE;
                o_step.rsp.kind       = ptw_pkg::KIND_READ;
                o_step.rsp.read_addr  = {20'd0, i_cfg.pdpt_base,
                                         i_item.lin_addr[31:30], 3'd0};
            end
        end else if (i_level != ptw_pkg::LVL_IDLE) begin
            o_step.emit = 1'b1;
            if (!i_item.read_ok) begin
                o_step.next_level = ptw_pkg::LVL_IDLE;
                o_step.rsp.kind   = ptw_pkg::KIND_DONE;
                o_step.rsp.status = ptw_pkg::STATUS_READ_FAULT;
            end else if (!w_e[0]) begin
                o_step.next_level = ptw_pkg::LVL_IDLE;
                o_step.rsp.kind   = ptw_pkg::KIND_DONE;
                o_step.rsp.status = ptw_pkg::STATUS_PAGE_FAULT;
            end else begin
                unique case (i_level)
                    ptw_pkg::LVL_PDPTE: begin
                        o_step.next_level    = ptw_pkg::LVL_PDE;
                        o_step.rsp.kind      = ptw_pkg::KIND_READ;
                        o_step.rsp.read_addr = {w_e[51:12], i_linear[29:21], 3'd0};
                    end
                    ptw_pkg::LVL_PDE: begin
                        if ((w_e & w_pde_rsv) != '0) begin
                            o_step.next_level = ptw_pkg::LVL_IDLE;
                            o_step.rsp.kind   = ptw_pkg::KIND_DONE;
                            o_step.rsp.status = ptw_pkg::STATUS_PAGE_FAULT;
                        end else if (w_large) begin
                            o_step.next_level    = ptw_pkg::LVL_IDLE;
                            o_step.rsp.kind      = ptw_pkg::KIND_DONE;
                            o_step.rsp.xlat_addr = {w_e[51:21], i_linear[20:0]};
                        end else begin
                            o_step.next_level    = ptw_pkg::LVL_PTE;
                            o_step.rsp.kind      = ptw_pkg::KIND_READ;
                            o_step.rsp.read_addr = {w_e[51:12], i_linear[20:12], 3'd0};
                        end
                    end
                    ptw_pkg::LVL_PTE: begin
                        o_step.next_level = ptw_pkg::LVL_IDLE;
                        o_step.rsp.kind   = ptw_pkg::KIND_DONE;
                        if ((w_e & w_pte_rsv) != '0) begin
                            o_step.rsp.status = ptw_pkg::STATUS_PAGE_FAULT;
                        end else begin
                            o_step.rsp.xlat_addr = {w_e[51:12], i_linear[11:0]};
                        end
                    end
                    default: begin
                        o_step.emit = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

>>> hdl/pae_page_table_walker.sv
// ----------------------------------------------------------------------------
// PAE page table walker
// Walks a 32-bit linear address through PDPTE, PDE and PTE, emitting table
// read requests and a final physical address or fault status.
//
//   Channel   Dir   Handshake      Content
//   i_req     in    valid/ready    op, lin_addr, read_data, read_ok
//   o_rsp     out   valid/ready    kind, read_addr, xlat_addr, status
//   i_cfg_*   in    write enable   register index, write data
//
// One item per cycle sustained while the result channel is not stalled; an item
// is held in the input register and its result in the result register, so a
// result transaction follows the item's transaction through both registers.
// Reset clears the walk level, the linear address and both valid flags, and
// returns the configuration to its defaults (MAXPHYADDR 36, PAT on, NX off).
// A stalled result holds the result register; the input register still takes
// one more item, and i_req.ready drops only while both registers are full.
// Items that arrive out of walk order are consumed without a result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pae_page_table_walker_defines.svh"

module pae_page_table_walker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ptw_req_if.sink                           i_req,
    ptw_rsp_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [ptw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ptw_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    ptw_pkg::t_cfg               w_cfg;
    ptw_pkg::t_step              w_step;
    ptw_pkg::t_req               w_req;
    logic                        w_adv;

    logic                        r_s1_valid;
    ptw_pkg::t_req               r_s1;
    ptw_pkg::t_level             r_level;
    logic [ptw_pkg::VA_W-1:0]    r_linear;
    logic                        r_out_valid;
    ptw_pkg::t_rsp               r_out;

    ptw_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    ptw_entry_check u_check (
        .i_level  (r_level),
        .i_linear (r_linear),
        .i_item   (r_s1),
        .i_cfg    (w_cfg),
        .o_step   (w_step)
    );

    assign w_req.op        = i_req.op;
    assign w_req.lin_addr  = i_req.lin_addr;
    assign w_req.read_data = i_req.read_data;
    assign w_req.read_ok   = i_req.read_ok;

    // the held item is processed when the result register is free
    assign w_adv       = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_level     <= ptw_pkg::LVL_IDLE;
            r_linear    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (w_adv) begin
                r_level <= w_step.next_level;
                if (w_step.latch) begin
                    r_linear <= r_s1.lin_addr;
                end
                r_out_valid <= w_step.emit;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1 <= w_req;
        end
        if (w_adv && w_step.emit) begin
            r_out <= w_step.rsp;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.kind      = r_out.kind;
    assign o_rsp.read_addr = r_out.read_addr;
    assign o_rsp.xlat_addr = r_out.xlat_addr;
    assign o_rsp.status    = r_out.status;

    `PTW_ASSERT_NOW(a_read_req_clean, i_clk, i_rst_n,
        r_out_valid && (r_out.kind == ptw_pkg::KIND_READ),
        (r_out.status == ptw_pkg::STATUS_OK) && (r_out.xlat_addr == '0),
        "read request carries status or physical address")
    `PTW_ASSERT_NOW(a_status_legal, i_clk, i_rst_n,
        r_out_valid,
        (r_out.status == ptw_pkg::STATUS_OK) ||
            (r_out.status == ptw_pkg::STATUS_PAGE_FAULT) ||
            (r_out.status == ptw_pkg::STATUS_READ_FAULT),
        "illegal walk status")
    `PTW_ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n,
        w_adv && w_step.emit && (w_step.rsp.kind == ptw_pkg::KIND_DONE),
        r_level == ptw_pkg::LVL_IDLE,
        "walker not idle after finished walk")
    `PTW_ASSERT_NEXT(a_start_walk, i_clk, i_rst_n,
        w_adv && (r_s1.op == ptw_pkg::OP_TRANSLATE) && (r_level == ptw_pkg::LVL_IDLE),
        (r_level == ptw_pkg::LVL_PDPTE) && r_out_valid,
        "translate did not start a walk")

endmodule
